@@ design/bmhq_pkg.sv @@
// Shared types and codes for the binary min-heap queue.
package bmhq_pkg;

   localparam int DEPTH   = 256;
   localparam int KEY_W   = 32;
   localparam int TAG_W   = 16;
   localparam int COUNT_W = 9;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   localparam int REG_CAPACITY = 0;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [KEY_W-1:0] entry_key;
      logic [TAG_W-1:0] entry_tag;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [KEY_W-1:0]   min_key;
      logic [TAG_W-1:0]   min_tag;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

endpackage

@@ design/binary_min_heap_queue_top.sv @@
// Binary min-heap priority queue: top level with heap memory and sift sequencer.
// A user first wants to know: one command is handled at a time. A full insert,
// an empty extract or peek and the unused command go straight to the done state,
// and a peek first takes the root. An insert walks up one level at a time (read
// parent, then compare and write). An extract fetches the root and the last
// entry, then walks down one level at a time (read left child, read right child,
// compare and write). The pace is set by the single heap memory: one registered
// read port and one write port. The swapping entry is kept in a register (the
// moving item), so each level writes only the entry that moves the other way, and
// the moving item is written once at its final slot. The result waits in an output
// register; the next command is taken once it has been handed over. The memory
// needs no clearing: only slots below the fill count are ever used.
module binary_min_heap_queue_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bmhq_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bmhq_pkg::rsp_type        rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int DEPTH = bmhq_pkg::DEPTH;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = bmhq_pkg::COUNT_W;
   localparam int KW = bmhq_pkg::KEY_W;
   localparam int TW = bmhq_pkg::TAG_W;
   localparam int EW = KW + TW;
   localparam logic [CW:0] DEPTH_C = (CW+1)'(DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_UP_RD, S_UP_CMP, S_PEEK, S_ROOT, S_LAST,
      S_DN_RD, S_DN_RDR, S_DN_CMP, S_DONE
   } state_type;

   // heap memory, key and tag in one word
   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     cap_ff, cap_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [EW-1:0]     move_ff, move_in;   // moving item
   logic [EW-1:0]     left_ff, left_in;   // left child held while the right is read
   bmhq_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CW:0]   limit;
   logic [AW:0]   lchild, rchild;
   logic [AW-1:0] parent;
   logic [KW-1:0] mk, lk, rk;
   logic          has_l, has_r, take_r, go, up_swap, cfg_wr;

   always_comb begin
      limit  = ({1'b0, cap_ff} > DEPTH_C) ? DEPTH_C : {1'b0, cap_ff};
      lchild = {pos_ff, 1'b1};
      rchild = {pos_ff, 1'b1} + (AW+1)'(1);
      parent = AW'((pos_ff - AW'(1)) >> 1);
      mk = move_ff[EW-1:TW];
      lk = left_ff[EW-1:TW];
      rk = rd_ff[EW-1:TW];
      has_l = (CW+1)'(lchild) < {1'b0, count_ff};
      has_r = (CW+1)'(rchild) < {1'b0, count_ff};
      take_r = has_r && (rk < lk);
      go = (has_l && mk > lk) || (has_r && mk > rk);
      // moving item strictly below its parent, which rd_ff holds
      up_swap = (pos_ff != '0) && (mk < rk);
      cfg_wr = psel && penable && pwrite && pready &&
               (paddr == 3'(bmhq_pkg::REG_CAPACITY * 4));
   end

   assign pready    = 1'b1;
   assign prdata    = {{(32-CW){1'b0}}, cap_ff};
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // read address and write port follow the state; idle keeps the root prefetched
   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = move_ff;
      case (state_ff)
         S_UP_RD:  rd_addr = parent;
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (up_swap) wr_data = rd_ff;   // push parent down
         end
         S_ROOT:   rd_addr = AW'(count_ff);   // last entry, just past the shrunk heap
         S_DN_RD: begin
            rd_addr = AW'(lchild);
            wr_en   = !has_l;   // leaf reached: settle moving item
         end
         S_DN_RDR: rd_addr = AW'(rchild);
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (go) wr_data = take_r ? rd_ff : left_ff;   // pull child up
         end
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      pos_in       = pos_ff;
      move_in      = move_ff;
      left_in      = left_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cfg_wr) cap_in = pwdata[CW-1:0];
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_in   = '{bmhq_pkg::ST_OK, '0, '0, count_ff};
               move_in  = {req_data.entry_key, req_data.entry_tag};
               pos_in   = AW'(count_ff);
               state_in = S_DONE;
               if (req_data.command == bmhq_pkg::CMD_INSERT) begin
                  if ({1'b0, count_ff} < limit) begin
                     count_in = count_ff + CW'(1);
                     rsp_in.entry_count = count_ff + CW'(1);
                     state_in = S_UP_RD;
                  end else begin
                     rsp_in.status = bmhq_pkg::ST_FULL;
                  end
               end else if (req_data.command inside
                            {bmhq_pkg::CMD_EXTRACT, bmhq_pkg::CMD_PEEK}) begin
                  if (count_ff == '0) begin
                     rsp_in.status = bmhq_pkg::ST_EMPTY;
                  end else if (req_data.command == bmhq_pkg::CMD_EXTRACT) begin
                     count_in = count_ff - CW'(1);
                     rsp_in.entry_count = count_ff - CW'(1);
                     state_in = S_ROOT;
                  end else begin
                     state_in = S_PEEK;
                  end
               end
            end
         end
         S_UP_RD: state_in = S_UP_CMP;
         S_UP_CMP: begin
            if (up_swap) begin
               pos_in   = parent;
               state_in = S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PEEK: begin
            rsp_in.min_key = rd_ff[EW-1:TW];
            rsp_in.min_tag = rd_ff[TW-1:0];
            state_in = S_DONE;
         end
         S_ROOT: begin
            // hand the root over, fetch the last entry
            rsp_in.min_key = rd_ff[EW-1:TW];
            rsp_in.min_tag = rd_ff[TW-1:0];
            state_in = S_LAST;
         end
         S_LAST: begin
            move_in  = rd_ff;
            pos_in   = '0;
            state_in = S_DN_RD;
         end
         S_DN_RD: state_in = has_l ? S_DN_RDR : S_DONE;
         S_DN_RDR: begin
            left_in  = rd_ff;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (go) begin
               pos_in   = take_r ? AW'(rchild) : AW'(lchild);
               state_in = S_DN_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CW'(256);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff  <= pos_in;
      move_ff <= move_in;
      left_ff <= left_in;
      rsp_ff  <= rsp_in;
   end

   // Hold a waiting result item steady until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data));

   // Take no new item while a result waits.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready);

   // Keep the fill count within the memory.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH));

   // Raise a result only on leaving the done state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_DONE);

endmodule
